// ===== sv/one_wire_bus_master_assert.svh =====
// assertion macros shared by the bus master rtl
// expects i_clk and i_rst_n in the including module's scope
`ifndef ONE_WIRE_BUS_MASTER_ASSERT_SVH
`define ONE_WIRE_BUS_MASTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define OWBM_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/owbm_pkg.sv =====
// shared types and constants of the 1-wire bus master
// no dependencies
package owbm_pkg;

    localparam int unsigned TIMER_WIDTH = 10;
    localparam int unsigned TIMER_MAX   = (2 ** TIMER_WIDTH) - 1;
    localparam int unsigned CFG_W       = 10;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned Q_DEPTH     = 2;
    localparam int unsigned QPTR_W      = $clog2(Q_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(Q_DEPTH + 1);

    // request opcodes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_RESET = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // command kinds, also the done_kind codes
    typedef enum logic [1:0] {
        KIND_RESET = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_LOW    = 3'd0,
        CFG_PRESENCE     = 3'd1,
        CFG_SLOT_LOW     = 3'd2,
        CFG_WRITE_ZERO   = 3'd3,
        CFG_READ_SAMPLE  = 3'd4,
        CFG_READ_RECOVER = 3'd5
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_RESET_LOW    = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE     = 10'd60;
    localparam logic [CFG_W-1:0] RST_SLOT_LOW     = 10'd1;
    localparam logic [CFG_W-1:0] RST_WRITE_ZERO   = 10'd60;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE  = 10'd14;
    localparam logic [CFG_W-1:0] RST_READ_RECOVER = 10'd45;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data_byte;
        logic       line_level;
    } t_req;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [1:0] done_kind;
        logic [7:0] read_data;
        logic       no_presence;
    } t_res;

    // classified request as it sits in the queue
    typedef struct packed {
        logic       start;
        t_kind      kind;
        logic [7:0] data_byte;
        logic       line_level;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_wait_time;
        logic [CFG_W-1:0] slot_low_time;
        logic [CFG_W-1:0] write_zero_extra_time;
        logic [CFG_W-1:0] read_sample_time;
        logic [CFG_W-1:0] read_recover_time;
    } t_cfg;

endpackage

// ===== sv/owbm_front.sv =====
// request intake: decodes opcodes and queues classified commands
// depends on owbm_pkg and one_wire_bus_master_assert.svh
`include "one_wire_bus_master_assert.svh"

module owbm_front
    import owbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_req i_data,
    output logic o_stall,
    output logic o_cmd_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    t_cmd              r_q [Q_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              grow;
    t_cmd              cmd_in;

    assign o_stall     = (r_count == QCNT_W'(Q_DEPTH));
    assign push        = i_valid && !o_stall;
    assign grow        = push && !i_pop;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    // classify
    always_comb begin
        cmd_in.data_byte  = i_data.data_byte;
        cmd_in.line_level = i_data.line_level;
        cmd_in.start      = 1'b1;
        cmd_in.kind       = KIND_RESET;
        unique case (t_op'(i_data.op))
            OP_RESET: cmd_in.kind = KIND_RESET;
            OP_WRITE: cmd_in.kind = KIND_WRITE;
            OP_READ:  cmd_in.kind = KIND_READ;
            default:  cmd_in.start = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (i_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            if (push && !i_pop) begin
                r_count <= QCNT_W'(r_count + 1'b1);
            end else if (!push && i_pop) begin
                r_count <= QCNT_W'(r_count - 1'b1);
            end
        end
    end

    `OWBM_ASSERT_IMPLY(a_pop_not_empty, i_pop, r_count != '0, "pop from empty queue")
    `OWBM_ASSERT_IMPLY(a_count_bound, 1'b1, r_count <= QCNT_W'(Q_DEPTH), "queue overfilled")
    `OWBM_ASSERT_NEXT(a_count_up, grow, r_count == $past(r_count) + 1'b1, "count lost a request")

endmodule

// ===== sv/owbm_engine.sv =====
// bus sequencer: runs one queued request per step and registers the result
// depends on owbm_pkg and one_wire_bus_master_assert.svh
`include "one_wire_bus_master_assert.svh"

module owbm_engine
    import owbm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_valid,
    output t_res o_data,
    input  logic i_stall
);

    localparam logic [2:0] BIT_LAST = 3'd7;

    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_RST_LOW    = 8'b0000_0010,
        PH_RST_WAIT   = 8'b0000_0100,
        PH_SLOT_GAP   = 8'b0000_1000,
        PH_SLOT_LOW   = 8'b0001_0000,
        PH_W0_LOW     = 8'b0010_0000,
        PH_RD_WAIT    = 8'b0100_0000,
        PH_RD_RECOVER = 8'b1000_0000
    } t_phase;

    function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return TIMER_WIDTH'(1);
        end else if (32'(v) > TIMER_MAX) begin
            return TIMER_WIDTH'(TIMER_MAX);
        end
        return TIMER_WIDTH'(v);
    endfunction

    t_phase                 r_phase, n_phase;
    logic [TIMER_WIDTH-1:0] r_time, n_time;
    logic [2:0]             r_bit, n_bit;
    logic [7:0]             r_shift, n_shift;
    t_kind                  r_kind, n_kind;
    logic                   r_drive, n_drive;
    logic                   r_out_valid;
    t_res                   r_out;

    logic                   pop;
    logic [TIMER_WIDTH-1:0] t_dec;
    logic                   done;
    logic                   presence;
    logic                   write_end;
    logic                   read_end;
    t_res                   res;
    logic                   timed_phase;
    logic                   low_phase;
    logic                   step_match;

    // output register frees up when taken
    assign pop       = i_cmd_valid && (!r_out_valid || !i_stall);
    assign o_cmd_pop = pop;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;
    assign t_dec     = TIMER_WIDTH'(r_time - 1'b1);

    assign timed_phase = (r_phase != PH_IDLE) && (r_phase != PH_SLOT_GAP);
    assign low_phase   = (r_phase == PH_RST_LOW) || (r_phase == PH_SLOT_LOW)
                         || (r_phase == PH_W0_LOW);
    assign step_match  = r_out_valid && (r_out.busy_res == (r_phase != PH_IDLE));

    always_comb begin
        n_phase   = r_phase;
        n_time    = r_time;
        n_bit     = r_bit;
        n_shift   = r_shift;
        n_kind    = r_kind;
        n_drive   = r_drive;
        done      = 1'b0;
        presence  = 1'b0;
        write_end = 1'b0;
        read_end  = 1'b0;
        if (pop) begin
            priority if (r_phase == PH_IDLE) begin
                if (i_cmd.start) begin
                    n_kind = i_cmd.kind;
                    unique case (i_cmd.kind)
                        KIND_RESET: begin
                            n_drive = 1'b1;
                            n_phase = PH_RST_LOW;
                            n_time  = timer_load(i_cfg.reset_low_time);
                        end
                        KIND_WRITE, KIND_READ: begin
                            n_shift = (i_cmd.kind == KIND_WRITE) ? i_cmd.data_byte : '0;
                            n_bit   = '0;
                            n_drive = 1'b1;
                            n_phase = PH_SLOT_LOW;
                            n_time  = timer_load(i_cfg.slot_low_time);
                        end
                        default: n_kind = r_kind;
                    endcase
                end
            end else if (r_phase == PH_SLOT_GAP) begin
                n_drive = 1'b1;
                n_phase = PH_SLOT_LOW;
                n_time  = timer_load(i_cfg.slot_low_time);
            end else begin
                n_time = t_dec;
                if (t_dec == '0) begin
                    unique case (r_phase)
                        PH_RST_LOW: begin
                            n_drive = 1'b0;
                            n_phase = PH_RST_WAIT;
                            n_time  = timer_load(i_cfg.presence_wait_time);
                        end
                        PH_RST_WAIT: begin
                            presence = i_cmd.line_level;
                            n_phase  = PH_IDLE;
                            done     = 1'b1;
                        end
                        PH_SLOT_LOW: begin
                            if (r_kind == KIND_WRITE) begin
                                if (r_shift[0]) begin
                                    write_end = 1'b1;
                                end else begin
                                    n_phase = PH_W0_LOW;
                                    n_time  = timer_load(i_cfg.write_zero_extra_time);
                                end
                            end else begin
                                n_drive = 1'b0;
                                n_phase = PH_RD_WAIT;
                                n_time  = timer_load(i_cfg.read_sample_time);
                            end
                        end
                        PH_W0_LOW: write_end = 1'b1;
                        PH_RD_WAIT: begin
                            n_shift = {i_cmd.line_level, r_shift[7:1]};
                            if (i_cfg.read_recover_time == '0) begin
                                read_end = 1'b1;
                            end else begin
                                n_phase = PH_RD_RECOVER;
                                n_time  = timer_load(i_cfg.read_recover_time);
                            end
                        end
                        PH_RD_RECOVER: read_end = 1'b1;
                        default: begin
                            n_phase = PH_IDLE;
                            n_drive = 1'b0;
                        end
                    endcase
                end
            end

            // end of a bit slot
            if (write_end || read_end) begin
                if (write_end) begin
                    n_drive = 1'b0;
                    n_shift = {1'b0, r_shift[7:1]};
                end
                if (r_bit == BIT_LAST) begin
                    n_phase = PH_IDLE;
                    n_bit   = '0;
                    done    = 1'b1;
                end else begin
                    n_bit = 3'(r_bit + 1'b1);
                    if (write_end) begin
                        n_phase = PH_SLOT_GAP;
                    end else begin
                        n_drive = 1'b1;
                        n_phase = PH_SLOT_LOW;
                        n_time  = timer_load(i_cfg.slot_low_time);
                    end
                end
            end
        end
    end

    always_comb begin
        res.drive_low   = n_drive;
        res.busy_res    = (n_phase != PH_IDLE);
        res.done_res    = done;
        res.done_kind   = done ? 2'(n_kind) : 2'(KIND_RESET);
        res.read_data   = (done && n_kind == KIND_READ) ? n_shift : '0;
        res.no_presence = done && (n_kind == KIND_RESET) && presence;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_time      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_kind      <= KIND_RESET;
            r_drive     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_time  <= n_time;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_kind  <= n_kind;
            r_drive <= n_drive;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_out <= res;
        end
    end

    `OWBM_ASSERT_IMPLY(a_timer_live, timed_phase, r_time != '0, "timed phase with empty timer")
    `OWBM_ASSERT_IMPLY(a_low_phase_drives, low_phase, r_drive, "low phase with line released")
    `OWBM_ASSERT_NEXT(a_pop_gives_result, pop, step_match, "step result lost or out of step")

endmodule

// ===== sv/one_wire_bus_master.sv =====
// top level of the 1-wire bus master: configuration registers, intake and sequencer
// depends on owbm_pkg, owbm_front and owbm_engine
//
// Each request is one microsecond tick: op 0 is a plain tick, 1 starts a
// reset with presence detect, 2 writes data_byte lsb first, 3 reads a byte
// lsb first. A request that starts a command while one is running counts as
// a plain tick. Every request yields exactly one result carrying the line
// drive, busy, and on completion the kind, read byte or presence flag.
// Throughput is one request per clock while the result channel does not
// stall; a request's result passes through the intake queue and then the
// sequencer's output register, and the sequencer takes one step per request.
// A two-entry queue sits between intake and sequencer so a stalled result
// does not block intake at once. The user must write timing registers through
// the configuration port only while the master is idle; no logic enforces it.
module one_wire_bus_master
    import owbm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    input  t_req                 i_data,
    output logic                 o_stall,
    // result channel
    output logic                 o_valid,
    output t_res                 o_data,
    input  logic                 i_stall,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // registers always accept a write
    assign o_cfg_ready = 1'b1;

    // timing registers, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low_time        <= RST_RESET_LOW;
            r_cfg.presence_wait_time    <= RST_PRESENCE;
            r_cfg.slot_low_time         <= RST_SLOT_LOW;
            r_cfg.write_zero_extra_time <= RST_WRITE_ZERO;
            r_cfg.read_sample_time      <= RST_READ_SAMPLE;
            r_cfg.read_recover_time     <= RST_READ_RECOVER;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_RESET_LOW:    r_cfg.reset_low_time        <= i_cfg_data;
                CFG_PRESENCE:     r_cfg.presence_wait_time    <= i_cfg_data;
                CFG_SLOT_LOW:     r_cfg.slot_low_time         <= i_cfg_data;
                CFG_WRITE_ZERO:   r_cfg.write_zero_extra_time <= i_cfg_data;
                CFG_READ_SAMPLE:  r_cfg.read_sample_time      <= i_cfg_data;
                CFG_READ_RECOVER: r_cfg.read_recover_time     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // intake: decode and queue
    owbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_pop       (cmd_pop)
    );

    // sequencer: one bus step per queued request
    owbm_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall)
    );

endmodule

// ===== tb/one_wire_bus_master_tb.sv =====
// self-checking testbench for the 1-wire bus master: directed and random tick requests
// depends on owbm_pkg and one_wire_bus_master; a built-in cycle predictor checks every result
module one_wire_bus_master_tb;
    import owbm_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 900;

    // sequencer phases as the predictor tracks them
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_RST_LOW,
        SEQ_RST_WAIT,
        SEQ_GAP,
        SEQ_SLOT_LOW,
        SEQ_W0_LOW,
        SEQ_RD_WAIT,
        SEQ_RD_RECOVER
    } t_seq;

    // how the bus line is driven back to the master
    typedef enum logic [1:0] {
        LINE_LOW,
        LINE_HIGH,
        LINE_RANDOM
    } t_line_mode;

    // predicts one result per request and holds the results still to come
    class bus_master_tracker;
        t_cfg                   cfg;
        t_seq                   seq;
        logic [TIMER_WIDTH-1:0] ticks_left;
        logic [2:0]             bit_idx;
        logic [7:0]             shreg;
        t_kind                  kind;
        logic                   pull;
        t_res                   pending_results[$];
        int                     errors;

        function new();
            cfg = '{reset_low_time: RST_RESET_LOW, presence_wait_time: RST_PRESENCE,
                    slot_low_time: RST_SLOT_LOW, write_zero_extra_time: RST_WRITE_ZERO,
                    read_sample_time: RST_READ_SAMPLE, read_recover_time: RST_READ_RECOVER};
            seq        = SEQ_IDLE;
            ticks_left = '0;
            bit_idx    = '0;
            shreg      = '0;
            kind       = KIND_RESET;
            pull       = 1'b0;
            errors     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_RESET_LOW:    cfg.reset_low_time        = v;
                CFG_PRESENCE:     cfg.presence_wait_time    = v;
                CFG_SLOT_LOW:     cfg.slot_low_time         = v;
                CFG_WRITE_ZERO:   cfg.write_zero_extra_time = v;
                CFG_READ_SAMPLE:  cfg.read_sample_time      = v;
                CFG_READ_RECOVER: cfg.read_recover_time     = v;
                default: ;
            endcase
        endfunction

        // zero counts as one tick, large values saturate
        function logic [TIMER_WIDTH-1:0] load_time(logic [CFG_W-1:0] v);
            if (v == '0)
                return TIMER_WIDTH'(1);
            if (v > TIMER_MAX)
                return TIMER_WIDTH'(TIMER_MAX);
            return TIMER_WIDTH'(v);
        endfunction

        function void open_slot();
            pull       = 1'b1;
            seq        = SEQ_SLOT_LOW;
            ticks_left = load_time(cfg.slot_low_time);
        endfunction

        function logic end_of_bit();
            if (bit_idx == 3'd7) begin
                seq     = SEQ_IDLE;
                bit_idx = '0;
                return 1'b1;
            end
            bit_idx = bit_idx + 3'd1;
            return 1'b0;
        endfunction

        function logic end_write_bit();
            pull  = 1'b0;
            shreg = shreg >> 1;
            if (end_of_bit())
                return 1'b1;
            seq = SEQ_GAP;
            return 1'b0;
        endfunction

        function logic end_read_bit();
            if (end_of_bit())
                return 1'b1;
            open_slot();
            return 1'b0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function logic busy();
            return seq != SEQ_IDLE;
        endfunction

        // one tick of the master for an accepted request
        function void note_request(t_req r);
            logic done;
            logic presence;
            t_res res;
            done     = 1'b0;
            presence = 1'b0;
            if (seq == SEQ_IDLE) begin
                if (r.op == OP_RESET) begin
                    kind       = KIND_RESET;
                    pull       = 1'b1;
                    seq        = SEQ_RST_LOW;
                    ticks_left = load_time(cfg.reset_low_time);
                end else if (r.op == OP_WRITE || r.op == OP_READ) begin
                    if (r.op == OP_WRITE) begin
                        kind  = KIND_WRITE;
                        shreg = r.data_byte;
                    end else begin
                        kind  = KIND_READ;
                        shreg = '0;
                    end
                    bit_idx = '0;
                    open_slot();
                end
            end else if (seq == SEQ_GAP) begin
                open_slot();
            end else begin
                ticks_left = ticks_left - 1'b1;
                if (ticks_left == '0) begin
                    case (seq)
                        SEQ_RST_LOW: begin
                            pull       = 1'b0;
                            seq        = SEQ_RST_WAIT;
                            ticks_left = load_time(cfg.presence_wait_time);
                        end
                        SEQ_RST_WAIT: begin
                            presence = r.line_level;
                            seq      = SEQ_IDLE;
                            done     = 1'b1;
                        end
                        SEQ_SLOT_LOW: begin
                            if (kind == KIND_WRITE) begin
                                if (shreg[0]) begin
                                    done = end_write_bit();
                                end else begin
                                    seq        = SEQ_W0_LOW;
                                    ticks_left = load_time(cfg.write_zero_extra_time);
                                end
                            end else begin
                                pull       = 1'b0;
                                seq        = SEQ_RD_WAIT;
                                ticks_left = load_time(cfg.read_sample_time);
                            end
                        end
                        SEQ_W0_LOW: done = end_write_bit();
                        SEQ_RD_WAIT: begin
                            shreg = {r.line_level, shreg[7:1]};
                            if (cfg.read_recover_time == '0) begin
                                done = end_read_bit();
                            end else begin
                                seq        = SEQ_RD_RECOVER;
                                ticks_left = load_time(cfg.read_recover_time);
                            end
                        end
                        SEQ_RD_RECOVER: done = end_read_bit();
                        default: begin
                            seq  = SEQ_IDLE;
                            pull = 1'b0;
                        end
                    endcase
                end
            end
            res             = '0;
            res.drive_low   = pull;
            res.busy_res    = (seq != SEQ_IDLE);
            res.done_res    = done;
            if (done)
                res.done_kind = kind;
            if (done && kind == KIND_READ)
                res.read_data = shreg;
            if (done && kind == KIND_RESET)
                res.no_presence = presence;
            pending_results.push_back(res);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending_results.size() == 0) begin
                $error("result with no request waiting");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.drive_low !== want.drive_low) begin
                $error("drive_low: expected %0d, got %0d", want.drive_low, got.drive_low);
                errors++;
            end
            if (got.busy_res !== want.busy_res) begin
                $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
                errors++;
            end
            if (got.done_res !== want.done_res) begin
                $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
                errors++;
            end
            if (got.done_kind !== want.done_kind) begin
                $error("done_kind: expected %0d, got %0d", want.done_kind, got.done_kind);
                errors++;
            end
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected 0x%02h, got 0x%02h", want.read_data,
                       got.read_data);
                errors++;
            end
            if (got.no_presence !== want.no_presence) begin
                $error("no_presence: expected %0d, got %0d", want.no_presence,
                       got.no_presence);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    t_req                 i_data      = '0;
    logic                 o_stall;
    logic                 o_valid;
    t_res                 o_data;
    logic                 i_stall     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    bus_master_tracker tracker;
    int                n_sent  = 0;
    logic              in_calm = 1'b0;
    logic              out_calm = 1'b0;
    int                idle_cycles = 0;

    one_wire_bus_master u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data      (i_data),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_data      (o_data),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 unit clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 0;
    end

    // ends the run when nothing moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)
                || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic line_bit(t_line_mode mode);
        case (mode)
            LINE_LOW:  return 1'b0;
            LINE_HIGH: return 1'b1;
            default:   return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // mostly short timings so the random part covers many commands
    function automatic logic [CFG_W-1:0] small_time();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
            return CFG_W'($urandom_range(0, 3));
        if (pick < 9)
            return CFG_W'($urandom_range(4, 12));
        return CFG_W'($urandom_range(13, 40));
    endfunction

    // present one request after a random gap, return at the edge that takes it
    task automatic send_request(t_req r);
        int gap;
        if (n_sent % 50 == 0)
            in_calm = ($urandom_range(0, 3) == 0);
        gap = in_calm ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_request(r);
        n_sent++;
    endtask

    // tick until the predicted master is idle; noise_pct of the ticks carry a
    // random op, which a busy master must ignore
    task automatic tick_until_idle(t_line_mode mode, int noise_pct);
        t_req r;
        while (tracker.busy()) begin
            r.op = OP_TICK;
            if ($urandom_range(0, 99) < noise_pct)
                r.op = t_op'($urandom_range(OP_TICK, OP_READ));
            r.data_byte  = 8'($urandom);
            r.line_level = line_bit(mode);
            send_request(r);
        end
    endtask

    task automatic run_command(t_op op, logic [7:0] data, t_line_mode mode, int noise_pct);
        send_request('{op: op, data_byte: data, line_level: line_bit(mode)});
        tick_until_idle(mode, noise_pct);
    endtask

    // write every timing register once the master has drained
    task automatic apply_timing(t_cfg c);
        t_cfg_idx         order[6];
        logic [CFG_W-1:0] v;
        order = '{CFG_RESET_LOW, CFG_PRESENCE, CFG_SLOT_LOW, CFG_WRITE_ZERO,
                  CFG_READ_SAMPLE, CFG_READ_RECOVER};
        i_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        foreach (order[k]) begin
            case (order[k])
                CFG_RESET_LOW:    v = c.reset_low_time;
                CFG_PRESENCE:     v = c.presence_wait_time;
                CFG_SLOT_LOW:     v = c.slot_low_time;
                CFG_WRITE_ZERO:   v = c.write_zero_extra_time;
                CFG_READ_SAMPLE:  v = c.read_sample_time;
                default:          v = c.read_recover_time;
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= order[k];
            i_cfg_data  <= v;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            tracker.set_reg(order[k], v);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random stall per result, checked at the edge that takes it
    initial begin
        int hold;
        int n_taken;
        n_taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (n_taken % 40 == 0)
                out_calm = ($urandom_range(0, 3) == 0);
            n_taken++;
            hold = out_calm ? 0 : $urandom_range(0, 5);
            if (hold != 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (o_valid !== 1'b1) @(posedge i_clk);
            tracker.check_result(o_data);
        end
    end

    initial begin
        t_cfg timing;
        int   random_end;
        int   segment_end;
        tracker = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // power-on timing: one full-length reset with presence detect
        timing = '{reset_low_time: RST_RESET_LOW, presence_wait_time: RST_PRESENCE,
                   slot_low_time: RST_SLOT_LOW, write_zero_extra_time: RST_WRITE_ZERO,
                   read_sample_time: RST_READ_SAMPLE, read_recover_time: RST_READ_RECOVER};
        apply_timing(timing);
        run_command(OP_RESET, 8'h00, LINE_LOW, 0);

        // shortest timing, recovery skipped
        timing = '{reset_low_time: 10'd1, presence_wait_time: 10'd1, slot_low_time: 10'd1,
                   write_zero_extra_time: 10'd1, read_sample_time: 10'd1,
                   read_recover_time: 10'd0};
        apply_timing(timing);
        run_command(OP_RESET, 8'h00, LINE_HIGH, 0);
        run_command(OP_RESET, 8'h00, LINE_LOW, 0);
        run_command(OP_WRITE, 8'h00, LINE_RANDOM, 0);
        run_command(OP_WRITE, 8'hFF, LINE_RANDOM, 0);
        run_command(OP_READ, 8'h00, LINE_HIGH, 0);
        run_command(OP_READ, 8'h00, LINE_LOW, 0);
        // tick while idle does nothing
        run_command(OP_TICK, 8'hFF, LINE_HIGH, 0);
        // commands arriving mid-command are ignored
        run_command(OP_WRITE, 8'h3C, LINE_RANDOM, 50);
        run_command(OP_READ, 8'h00, LINE_RANDOM, 50);

        // zero in every register: one-tick phases, no read recovery
        apply_timing('0);
        run_command(OP_WRITE, 8'h5A, LINE_RANDOM, 0);
        run_command(OP_READ, 8'h00, LINE_RANDOM, 0);
        run_command(OP_RESET, 8'h00, LINE_HIGH, 30);

        // random part: short random timings, mostly complete commands with
        // random content, some idle ticks and commands dropped on a busy master
        random_end = n_sent + RANDOM_ITEMS;
        while (n_sent < random_end) begin
            timing.reset_low_time        = small_time();
            timing.presence_wait_time    = small_time();
            timing.slot_low_time         = small_time();
            timing.write_zero_extra_time = small_time();
            timing.read_sample_time      = small_time();
            timing.read_recover_time     = small_time();
            apply_timing(timing);
            segment_end = n_sent + $urandom_range(150, 300);
            while (n_sent < segment_end && n_sent < random_end) begin
                if ($urandom_range(0, 9) < 7)
                    run_command(t_op'($urandom_range(OP_RESET, OP_READ)), 8'($urandom),
                                LINE_RANDOM, ($urandom_range(0, 2) == 0) ? 10 : 0);
                else
                    run_command(t_op'($urandom_range(OP_TICK, OP_READ)), 8'($urandom),
                                LINE_RANDOM, 20);
            end
        end
        i_valid <= 1'b0;

        // drain, then allow for the pipeline latency
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== one_wire_bus_master.f =====
+incdir+sv
sv/owbm_pkg.sv
sv/owbm_front.sv
sv/owbm_engine.sv
sv/one_wire_bus_master.sv
tb/one_wire_bus_master_tb.sv
